// ===== sv/bsrf_pkg.sv =====
// Shared types and constants for the banked sound register file.
`default_nettype none

package bsrf_pkg;

    localparam int WAVE_DEPTH = 32;
    localparam int WAVE_AW    = 5;

    localparam logic [7:0] OPEN_BUS = 8'hFF;

    localparam logic [3:0] OFF_SEL      = 4'h0;
    localparam logic [3:0] OFF_MAIN_BAL = 4'h1;
    localparam logic [3:0] OFF_FREQ_LO  = 4'h2;
    localparam logic [3:0] OFF_FREQ_HI  = 4'h3;
    localparam logic [3:0] OFF_CTRL     = 4'h4;
    localparam logic [3:0] OFF_BAL      = 4'h5;
    localparam logic [3:0] OFF_WAVE     = 4'h6;
    localparam logic [3:0] OFF_NOISE    = 4'h7;
    localparam logic [3:0] OFF_LFO_FREQ = 4'h8;
    localparam logic [3:0] OFF_LFO_CTRL = 4'h9;

    localparam logic [1:0] MODE_WRITE     = 2'b00;
    localparam logic [1:0] MODE_DIRECT_ON = 2'b11;

    localparam int NOISE_CH_A = 4;
    localparam int NOISE_CH_B = 5;

    typedef struct packed {
        logic       wr;
        logic [3:0] offset;
        logic [7:0] data;
    } acc_t;

    // cdv: bit6 on, bit5 direct, bits4:0 volume; noise: bit5 enable, bits4:0 freq
    typedef struct packed {
        logic [11:0]        freq;
        logic [6:0]         cdv;
        logic [7:0]         pan;
        logic [WAVE_AW-1:0] ptr;
        logic [4:0]         dlatch;
        logic [5:0]         noise;
    } chan_t;

endpackage

`default_nettype wire

// ===== sv/bsrf_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none

module bsrf_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/bsrf_chan.sv =====
// One channel's banked register set and its write decode.
`default_nettype none

module bsrf_chan (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           hit,
    input  wire logic           noise_ok,
    input  wire bsrf_pkg::acc_t acc,
    output bsrf_pkg::chan_t     chan_next,
    output logic                wave_we
);

    import bsrf_pkg::*;

    chan_t chan_reg;

    always_comb
    begin
        chan_next = chan_reg;
        wave_we   = 1'b0;
        if (hit)
        begin
            unique case (acc.offset)
                OFF_FREQ_LO: chan_next.freq[7:0]  = acc.data;
                OFF_FREQ_HI: chan_next.freq[11:8] = acc.data[3:0];
                OFF_CTRL:
                begin
                    chan_next.cdv = {acc.data[7], acc.data[6], acc.data[4:0]};
                    if (acc.data[6])
                    begin
                        chan_next.ptr = '0;
                    end
                end
                OFF_BAL: chan_next.pan = acc.data;
                OFF_WAVE:
                begin
                    if (chan_reg.cdv[6:5] == MODE_WRITE)
                    begin
                        wave_we       = 1'b1;
                        chan_next.ptr = chan_reg.ptr + WAVE_AW'(1);
                    end
                    else if (chan_reg.cdv[6:5] == MODE_DIRECT_ON)
                    begin
                        chan_next.dlatch = acc.data[4:0];
                    end
                end
                OFF_NOISE:
                begin
                    if (noise_ok)
                    begin
                        chan_next.noise = {acc.data[7], acc.data[4:0]};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= '0;
        end
        else
        begin
            chan_reg <= chan_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/banked_sound_register_file.sv =====
// Top level: bus access register file of a wavetable sound generator.
//
//  channel | dir | fields (tdata, from bit 0)
//  s_*     | in  | operation[0] register_offset[4:1] write_data[12:5]
//  m_*     | out | read_data selected_channel chan_frequency chan_control chan_balance
//          |     | wave_address wave_entry direct_level noise_control main_balance
//          |     | lfo_frequency lfo_control
//
// One access per cycle while the result is not stalled.
// Stage one registers the access; stage two applies it and registers the snapshot,
// with the wave store's registered read giving wave_entry.
// Reset clears all state at once; wave entries never written read zero (valid bits).
// A stalled result holds; one access may wait in the input register meanwhile.
`default_nettype none

module banked_sound_register_file #(
    parameter int CHANNEL_COUNT = 6
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // operation, register_offset, write_data, 3 zero bits
    input  wire logic [15:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_data, selected_channel, chan_frequency, chan_control, chan_balance,
    // wave_address, wave_entry, direct_level, noise_control, main_balance,
    // lfo_frequency, lfo_control, 2 zero bits
    output logic [87:0]      m_tdata
);

    import bsrf_pkg::*;

    localparam int CH_W     = $clog2(CHANNEL_COUNT);
    localparam int WA_W     = CH_W + WAVE_AW;
    localparam int WS_DEPTH = CHANNEL_COUNT * WAVE_DEPTH;

    logic              in_valid_reg;
    acc_t              acc_reg;
    logic              advance;

    logic [2:0]        sel_reg, sel_next;
    logic [7:0]        main_reg, main_next;
    logic [7:0]        lfo_freq_reg, lfo_freq_next;
    logic [2:0]        lfo_mode_reg, lfo_mode_next;

    chan_t             chan_next_arr [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] wave_we;
    logic              wave_we_any;
    logic              sel_ok_next;
    chan_t             snap;

    logic [WA_W-1:0]   raddr, waddr;
    logic [4:0]        ram_q;
    logic [WS_DEPTH-1:0] vld_reg;

    logic              out_valid_reg;
    logic [2:0]        o_sel_reg;
    chan_t             o_chan_reg;
    logic              o_ok_reg;
    logic              o_ent_ok_reg;
    logic [7:0]        o_main_reg, o_lfo_freq_reg;
    logic [2:0]        o_lfo_mode_reg;
    logic [4:0]        o_entry;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            acc_reg <= '{wr: s_tdata[0], offset: s_tdata[4:1], data: s_tdata[12:5]};
        end
    end

    // global registers
    always_comb
    begin
        sel_next      = sel_reg;
        main_next     = main_reg;
        lfo_freq_next = lfo_freq_reg;
        lfo_mode_next = lfo_mode_reg;
        if (advance && acc_reg.wr)
        begin
            unique case (acc_reg.offset)
                OFF_SEL:      sel_next      = acc_reg.data[2:0];
                OFF_MAIN_BAL: main_next     = acc_reg.data;
                OFF_LFO_FREQ: lfo_freq_next = acc_reg.data;
                OFF_LFO_CTRL: lfo_mode_next = {acc_reg.data[7], acc_reg.data[1:0]};
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg      <= '0;
            main_reg     <= '0;
            lfo_freq_reg <= '0;
            lfo_mode_reg <= '0;
        end
        else
        begin
            sel_reg      <= sel_next;
            main_reg     <= main_next;
            lfo_freq_reg <= lfo_freq_next;
            lfo_mode_reg <= lfo_mode_next;
        end
    end

    for (genvar k = 0; k < CHANNEL_COUNT; k++)
    begin : g_chan
        bsrf_chan u_chan (
            .clk       (clk),
            .rst_n     (rst_n),
            .hit       (advance && acc_reg.wr && (sel_reg == 3'(k))),
            .noise_ok  ((k == NOISE_CH_A) || (k == NOISE_CH_B)),
            .acc       (acc_reg),
            .chan_next (chan_next_arr[k]),
            .wave_we   (wave_we[k])
        );
    end

    assign wave_we_any = |wave_we;
    assign sel_ok_next = ({1'b0, sel_next} < 4'(CHANNEL_COUNT));
    assign snap        = sel_ok_next ? chan_next_arr[sel_next[CH_W-1:0]] : '0;

    // a wave write keeps the select and advances the pointer by one
    assign raddr = {sel_next[CH_W-1:0], snap.ptr};
    assign waddr = {sel_reg[CH_W-1:0], snap.ptr - WAVE_AW'(1)};

    bsrf_ram #(
        .WIDTH (5),
        .DEPTH (WS_DEPTH)
    ) u_wave (
        .clk   (clk),
        .we    (wave_we_any),
        .waddr (waddr),
        .wdata (acc_reg.data[4:0]),
        .re    (advance && sel_ok_next),
        .raddr (raddr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wave_we_any)
        begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            o_sel_reg      <= sel_next;
            o_chan_reg     <= snap;
            o_ok_reg       <= sel_ok_next;
            o_ent_ok_reg   <= sel_ok_next && vld_reg[raddr];
            o_main_reg     <= main_next;
            o_lfo_freq_reg <= lfo_freq_next;
            o_lfo_mode_reg <= lfo_mode_next;
        end
    end

    assign o_entry  = o_ent_ok_reg ? ram_q : 5'd0;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        2'b00,
        o_lfo_mode_reg[2], 5'b0, o_lfo_mode_reg[1:0],
        o_lfo_freq_reg,
        o_main_reg,
        o_chan_reg.noise[5], 2'b0, o_chan_reg.noise[4:0],
        o_chan_reg.dlatch,
        o_entry,
        o_chan_reg.ptr,
        o_chan_reg.pan,
        o_chan_reg.cdv[6], o_chan_reg.cdv[5], 1'b0, o_chan_reg.cdv[4:0],
        o_chan_reg.freq,
        o_sel_reg,
        OPEN_BUS
    };

    a_one_wave_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(wave_we))
        else $error("more than one channel writes the wave store");

    a_wave_write_keeps_sel: assert property (@(posedge clk) disable iff (!rst_n)
        wave_we_any |-> (sel_next == sel_reg) && (raddr != waddr))
        else $error("wave write collides with snapshot read");

    a_read_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !acc_reg.wr |=> (sel_reg == $past(sel_reg))
            && (main_reg == $past(main_reg)) && (lfo_mode_reg == $past(lfo_mode_reg)))
        else $error("read access changed global state");

    a_reserved_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !o_ok_reg |-> (o_chan_reg == '0) && (o_entry == 5'd0))
        else $error("reserved select shows channel data");

    a_no_write_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        wave_we_any |-> ({1'b0, sel_reg} < 4'(CHANNEL_COUNT)))
        else $error("wave write with reserved select");

endmodule

`default_nettype wire

// ===== tb/bsrf_snapshot_checker.sv =====
// Checker for the banked sound register file: predicts each register snapshot and compares it.
module bsrf_snapshot_checker
    import bsrf_pkg::*;
#(
    parameter int CHANNEL_COUNT = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    output int          errors,
    output int          pending,
    output int          checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // read_data sits in the lowest bits of m_tdata
    typedef struct packed {
        logic [7:0]  lfo_control;
        logic [7:0]  lfo_frequency;
        logic [7:0]  main_balance;
        logic [7:0]  noise_control;
        logic [4:0]  direct_level;
        logic [4:0]  wave_entry;
        logic [4:0]  wave_address;
        logic [7:0]  chan_balance;
        logic [7:0]  chan_control;
        logic [11:0] chan_frequency;
        logic [2:0]  selected_channel;
        logic [7:0]  read_data;
    } snapshot_t;

    logic [2:0]         sel;
    logic [7:0]         main_bal;
    logic [7:0]         lfo_freq;
    logic               lfo_trig;
    logic [1:0]         lfo_mode;
    logic [11:0]        freq       [CHANNEL_COUNT];
    logic               on_bit     [CHANNEL_COUNT];
    logic               direct_bit [CHANNEL_COUNT];
    logic [4:0]         vol        [CHANNEL_COUNT];
    logic [7:0]         pan        [CHANNEL_COUNT];
    logic [WAVE_AW-1:0] wptr       [CHANNEL_COUNT];
    logic [4:0]         dlat       [CHANNEL_COUNT];
    logic               noise_en   [CHANNEL_COUNT];
    logic [4:0]         noise_freq [CHANNEL_COUNT];
    logic [4:0]         wave_mem   [CHANNEL_COUNT][WAVE_DEPTH];

    snapshot_t snapshot_queue [$];

    initial
    begin
        errors  = 0;
        pending = 0;
        checked = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic clear_state();
        sel      = '0;
        main_bal = '0;
        lfo_freq = '0;
        lfo_trig = 1'b0;
        lfo_mode = '0;
        for (int c = 0; c < CHANNEL_COUNT; c++)
        begin
            freq[c]       = '0;
            on_bit[c]     = 1'b0;
            direct_bit[c] = 1'b0;
            vol[c]        = '0;
            pan[c]        = '0;
            wptr[c]       = '0;
            dlat[c]       = '0;
            noise_en[c]   = 1'b0;
            noise_freq[c] = '0;
            for (int a = 0; a < WAVE_DEPTH; a++)
                wave_mem[c][a] = '0;
        end
    endtask

    task automatic apply_access(input logic wr, input logic [3:0] off, input logic [7:0] d);
        int ch;
        ch = sel;
        if (!wr)
            return;
        case (off)
            OFF_SEL:      sel = d[2:0];
            OFF_MAIN_BAL: main_bal = d;
            OFF_LFO_FREQ: lfo_freq = d;
            OFF_LFO_CTRL:
            begin
                lfo_trig = d[7];
                lfo_mode = d[1:0];
            end
            default:
            begin
                if (ch < CHANNEL_COUNT)
                begin
                    case (off)
                        OFF_FREQ_LO: freq[ch][7:0]  = d;
                        OFF_FREQ_HI: freq[ch][11:8] = d[3:0];
                        OFF_CTRL:
                        begin
                            on_bit[ch]     = d[7];
                            direct_bit[ch] = d[6];
                            vol[ch]        = d[4:0];
                            if (d[6])
                                wptr[ch] = '0;
                        end
                        OFF_BAL: pan[ch] = d;
                        OFF_WAVE:
                        begin
                            if ({on_bit[ch], direct_bit[ch]} == MODE_WRITE)
                            begin
                                wave_mem[ch][wptr[ch]] = d[4:0];
                                wptr[ch] = wptr[ch] + 1'b1;
                            end
                            else if ({on_bit[ch], direct_bit[ch]} == MODE_DIRECT_ON)
                                dlat[ch] = d[4:0];
                        end
                        OFF_NOISE:
                        begin
                            if (ch == NOISE_CH_A || ch == NOISE_CH_B)
                            begin
                                noise_en[ch]   = d[7];
                                noise_freq[ch] = d[4:0];
                            end
                        end
                        default: ;
                    endcase
                end
            end
        endcase
    endtask

    function automatic snapshot_t current_snapshot();
        snapshot_t snap;
        int        ch;
        snap                  = '0;
        ch                    = sel;
        snap.read_data        = OPEN_BUS;
        snap.selected_channel = sel;
        if (ch < CHANNEL_COUNT)
        begin
            snap.chan_frequency = freq[ch];
            snap.chan_control   = {on_bit[ch], direct_bit[ch], 1'b0, vol[ch]};
            snap.chan_balance   = pan[ch];
            snap.wave_address   = wptr[ch];
            snap.wave_entry     = wave_mem[ch][wptr[ch]];
            snap.direct_level   = dlat[ch];
            snap.noise_control  = {noise_en[ch], 2'b00, noise_freq[ch]};
        end
        snap.main_balance  = main_bal;
        snap.lfo_frequency = lfo_freq;
        snap.lfo_control   = {lfo_trig, 5'b00000, lfo_mode};
        return snap;
    endfunction

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want, input int idx);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      idx, name, got, want));
    endtask

    task automatic compare_snapshot(input logic [87:0] raw, input snapshot_t want,
                                    input int idx);
        snapshot_t got;
        got = raw[85:0];
        check_field("read_data",        got.read_data,        want.read_data,        idx);
        check_field("selected_channel", got.selected_channel, want.selected_channel, idx);
        check_field("chan_frequency",   got.chan_frequency,   want.chan_frequency,   idx);
        check_field("chan_control",     got.chan_control,     want.chan_control,     idx);
        check_field("chan_balance",     got.chan_balance,     want.chan_balance,     idx);
        check_field("wave_address",     got.wave_address,     want.wave_address,     idx);
        check_field("wave_entry",       got.wave_entry,       want.wave_entry,       idx);
        check_field("direct_level",     got.direct_level,     want.direct_level,     idx);
        check_field("noise_control",    got.noise_control,    want.noise_control,    idx);
        check_field("main_balance",     got.main_balance,     want.main_balance,     idx);
        check_field("lfo_frequency",    got.lfo_frequency,    want.lfo_frequency,    idx);
        check_field("lfo_control",      got.lfo_control,      want.lfo_control,      idx);
        check_field("pad bits",         raw[87:86],           2'b00,                 idx);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            snapshot_queue.delete();
            pending = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_access(s_tdata[0], s_tdata[4:1], s_tdata[12:5]);
                snapshot_queue.push_back(current_snapshot());
            end
            if (m_tvalid && m_tready)
            begin
                if (snapshot_queue.size() == 0)
                    report_mismatch($sformatf("unexpected result 0x%0h", m_tdata));
                else
                    compare_snapshot(m_tdata, snapshot_queue.pop_front(), checked);
                checked++;
            end
            pending = snapshot_queue.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: clock, reset, bus access stimulus, flow control and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bsrf_pkg::*;

    localparam int CH_COUNT = 6;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;

    int errors;
    int pending;
    int checked;
    int access_count = 0;
    int idle_pct     = 0;
    int stall_pct    = 0;

    logic [12:0] directed_accesses [25];

    always #10 clk = ~clk;

    banked_sound_register_file #(
        .CHANNEL_COUNT(CH_COUNT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    bsrf_snapshot_checker #(
        .CHANNEL_COUNT(CH_COUNT)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .errors(errors),
        .pending(pending),
        .checked(checked)
    );

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // entered and left just after a rising edge
    task automatic send_access(input logic wr, input logic [3:0] off, input logic [7:0] d);
        logic ok;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, d, off, wr};
        do
        begin
            @(negedge clk);
            ok = s_tready;
            @(posedge clk);
        end
        while (!ok);
        access_count++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic send_wave_run(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                send_access(1'b0, 4'($urandom_range(15)), 8'($urandom_range(255)));
            send_access(1'b1, OFF_WAVE, 8'($urandom_range(255)));
        end
    endtask

    task automatic run_random(input int target);
        int          pick;
        logic [2:0]  ch;
        logic [3:0]  off;
        while (access_count < target)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                send_access(1'($urandom), 4'($urandom_range(15)), 8'($urandom_range(255)));
            else if (pick < 20)
            begin
                ch = ($urandom_range(7) == 0) ? 3'($urandom_range(7, 6))
                                              : 3'($urandom_range(CH_COUNT - 1));
                send_access(1'b1, OFF_SEL, {5'($urandom), ch});
            end
            else if (pick < 45)
            begin
                // clear the address, drop to write mode, then fill past a wrap at times
                send_access(1'b1, OFF_CTRL, {2'b01, 6'($urandom)});
                send_access(1'b1, OFF_CTRL, {2'b00, 6'($urandom)});
                send_wave_run($urandom_range(1, 40));
            end
            else if (pick < 55)
            begin
                send_access(1'b1, OFF_CTRL, {2'b11, 6'($urandom)});
                send_wave_run($urandom_range(1, 4));
            end
            else if (pick < 60)
            begin
                send_access(1'b1, OFF_CTRL, {$urandom_range(1) ? 2'b10 : 2'b01, 6'($urandom)});
                send_wave_run($urandom_range(1, 3));
            end
            else if (pick < 75)
            begin
                case ($urandom_range(3))
                    0:       off = OFF_FREQ_LO;
                    1:       off = OFF_FREQ_HI;
                    2:       off = OFF_BAL;
                    default: off = OFF_NOISE;
                endcase
                send_access(1'b1, off, 8'($urandom_range(255)));
            end
            else if (pick < 85)
            begin
                case ($urandom_range(2))
                    0:       off = OFF_MAIN_BAL;
                    1:       off = OFF_LFO_FREQ;
                    default: off = OFF_LFO_CTRL;
                endcase
                send_access(1'b1, off, 8'($urandom_range(255)));
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    send_access(1'b0, 4'($urandom_range(15)), 8'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        directed_accesses = '{
            {1'b0, OFF_SEL,      8'h00},
            {1'b1, OFF_SEL,      8'hFF},
            {1'b1, OFF_FREQ_LO,  8'hAA},
            {1'b1, OFF_SEL,      8'h06},
            {1'b1, OFF_MAIN_BAL, 8'hFF},
            {1'b1, OFF_LFO_FREQ, 8'hFF},
            {1'b1, OFF_LFO_CTRL, 8'hFF},
            {1'b1, OFF_SEL,      8'hF8},
            {1'b1, OFF_FREQ_LO,  8'hFF},
            {1'b1, OFF_FREQ_HI,  8'hFF},
            {1'b1, OFF_CTRL,     8'h5F},
            {1'b1, OFF_WAVE,     8'h15},
            {1'b1, OFF_CTRL,     8'h1F},
            {1'b1, OFF_WAVE,     8'hFF},
            {1'b1, OFF_NOISE,    8'hFF},
            {1'b1, OFF_BAL,      8'hFF},
            {1'b1, OFF_CTRL,     8'hC0},
            {1'b1, OFF_WAVE,     8'h1F},
            {1'b1, OFF_CTRL,     8'h80},
            {1'b1, OFF_WAVE,     8'h0A},
            {1'b1, 4'hA,         8'hFF},
            {1'b1, 4'hF,         8'hFF},
            {1'b1, OFF_SEL,      8'h04},
            {1'b1, OFF_NOISE,    8'hFF},
            {1'b0, OFF_NOISE,    8'h00}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_accesses[i])
            send_access(directed_accesses[i][12], directed_accesses[i][11:8],
                        directed_accesses[i][7:0]);
        wait_drained();

        idle_pct  = 0;
        stall_pct = 0;
        run_random(access_count + 320);
        wait_drained();

        idle_pct  = 80;
        stall_pct = 0;
        run_random(access_count + 320);
        wait_drained();

        idle_pct  = 0;
        stall_pct = 80;
        run_random(access_count + 320);
        wait_drained();

        idle_pct  = 7;
        stall_pct = 7;
        run_random(access_count + 320);
        wait_drained();

        repeat (10) @(posedge clk);

        $display("Sent %0d bus accesses, checked %0d snapshots over four flow-control phases.",
                 access_count, checked);
        $display("Mix: reserved selects, wave runs with address wrap, direct and idle modes.");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("Timeout with %0d results outstanding", pending);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bsrf_pkg.sv
sv/bsrf_ram.sv
sv/bsrf_chan.sv
sv/banked_sound_register_file.sv
tb/bsrf_snapshot_checker.sv
tb/tb_top.sv
